>>> sv/ordered_list_buffer_unit_assert.svh
// Assertion macros for the ordered list buffer.
// Included by modules that check their own control logic.
`ifndef ORDERED_LIST_BUFFER_UNIT_ASSERT_SVH
`define ORDERED_LIST_BUFFER_UNIT_ASSERT_SVH

// Same-cycle implication
`define OLB_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define OLB_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/olb_pkg.sv
// Shared constants and types for the ordered list buffer.
// No dependencies; used by olb_cell, ordered_list_buffer_unit and the testbench.
package olb_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;
  // cells covered by one search step
  localparam int GROUP_SIZE     = 8;

  localparam logic [3:0] CMD_ADD_FIRST    = 4'd0;
  localparam logic [3:0] CMD_ADD_LAST     = 4'd1;
  localparam logic [3:0] CMD_INSERT_AT    = 4'd2;
  localparam logic [3:0] CMD_REMOVE_FIRST = 4'd3;
  localparam logic [3:0] CMD_REMOVE_LAST  = 4'd4;
  localparam logic [3:0] CMD_REMOVE_VALUE = 4'd5;
  localparam logic [3:0] CMD_CONTAINS     = 4'd6;
  localparam logic [3:0] CMD_HEAD         = 4'd7;
  localparam logic [3:0] CMD_TAIL         = 4'd8;
  localparam logic [3:0] CMD_CLEAR        = 4'd9;
  localparam logic [3:0] CMD_SIZE         = 4'd10;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  // broadcast controls for the cell row
  typedef struct packed {
    logic ins;      // open a slot at ins_pos, shift the rest up
    logic del_all;  // shift every cell down by one
    logic del_ge;   // shift down the cells at or after the first match
    logic scan;     // search step active
  } cell_ctl_t;

endpackage

>>> sv/ordered_list_buffer_unit.sv
// Ordered list buffer: a row of shift cells holding up to CAPACITY entries and a count.
// Adds, inserts, removes, head, clear and size answer in the cycle after acceptance,
// one per cycle unless the result side stalls. Contains, remove-by-value and tail on
// a non-empty list sweep GROUP_SIZE cells per step and block new commands meanwhile.
// Synchronous active-high reset empties the list; entry contents are not cleared.
// Depends on olb_pkg, olb_cell and ordered_list_buffer_unit_assert.svh.
`include "ordered_list_buffer_unit_assert.svh"

module ordered_list_buffer_unit #(
  parameter int CAPACITY   = olb_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = olb_pkg::DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [3:0]                     command,
  input  logic [DATA_WIDTH-1:0]          value,
  input  logic [$clog2(CAPACITY+1)-1:0]  position,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     status,
  output logic [DATA_WIDTH-1:0]          data_out,
  output logic                           found,
  output logic [$clog2(CAPACITY+1)-1:0]  count
);
  import olb_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NG = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam logic [GW-1:0] LAST_GRP = GW'(NG - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                state;
  logic [CW-1:0]         cnt;
  logic [CW-1:0]         cnt_next;
  logic [GW-1:0]         grp;
  logic                  carry;
  logic [DATA_WIDTH-1:0] acc;
  logic [DATA_WIDTH-1:0] key;
  logic [3:0]            cmd_q;

  cell_ctl_t             ctl;
  logic [CW-1:0]         ins_pos;
  logic [CW-1:0]         tail_pos;
  logic                  accept;
  logic                  out_free;
  logic                  start_scan;
  logic                  fin_load;
  logic                  empty;
  logic                  full;
  logic [1:0]            r_status;
  logic [DATA_WIDTH-1:0] r_data;

  logic [DATA_WIDTH-1:0] entries   [CAPACITY];
  logic [DATA_WIDTH-1:0] tail_term [CAPACITY];
  logic                  seen_out  [CAPACITY];
  logic                  grp_seen  [NG];
  logic [DATA_WIDTH-1:0] grp_tail  [NG];

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign fin_load = (state == S_FIN) && out_free;
  assign empty    = (cnt == '0);
  assign full     = (cnt >= CAP_C);
  assign tail_pos = cnt - 1'b1;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_e;
    logic [DATA_WIDTH-1:0] right_e;
    logic                  seen_i;
    if (i == 0) begin : g_first
      assign left_e = '0;
    end else begin : g_mid
      assign left_e = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
    end else begin : g_nlast
      assign right_e = entries[i+1];
    end
    if (i % GROUP_SIZE == 0) begin : g_grp_head
      assign seen_i = carry;
    end else begin : g_grp_body
      assign seen_i = seen_out[i-1];
    end

    olb_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .GW         (GW),
      .INDEX      (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .ins_pos     (ins_pos),
      .cnt         (cnt),
      .tail_pos    (tail_pos),
      .grp         (grp),
      .ins_data    (value),
      .key         (key),
      .left_entry  (left_e),
      .right_entry (right_e),
      .seen_in     (seen_i),
      .entry       (entries[i]),
      .seen_out    (seen_out[i]),
      .tail_term   (tail_term[i])
    );
  end

  // per-group search results
  for (genvar g = 0; g < NG; g++) begin : g_grp
    localparam int LAST_I = (g * GROUP_SIZE + GROUP_SIZE - 1 < CAPACITY) ?
                            (g * GROUP_SIZE + GROUP_SIZE - 1) : (CAPACITY - 1);
    assign grp_seen[g] = seen_out[LAST_I];
    always_comb begin
      grp_tail[g] = '0;
      for (int j = g * GROUP_SIZE; j <= LAST_I; j++) begin
        grp_tail[g] = grp_tail[g] | tail_term[j];
      end
    end
  end

  // command decode
  always_comb begin
    ctl        = '0;
    ins_pos    = position;
    r_status   = ST_OK;
    r_data     = '0;
    cnt_next   = cnt;
    start_scan = 1'b0;
    ctl.scan   = (state == S_SCAN);
    if (accept) begin
      case (command)
        CMD_ADD_FIRST: begin
          ins_pos = '0;
          if (full) begin
            r_status = ST_FULL;
          end else begin
            ctl.ins  = 1'b1;
            cnt_next = cnt + 1'b1;
          end
        end
        CMD_ADD_LAST: begin
          ins_pos = cnt;
          if (full) begin
            r_status = ST_FULL;
          end else begin
            ctl.ins  = 1'b1;
            cnt_next = cnt + 1'b1;
          end
        end
        CMD_INSERT_AT: begin
          if (position > cnt) begin
            r_status = ST_RANGE;
          end else if (full) begin
            r_status = ST_FULL;
          end else begin
            ctl.ins  = 1'b1;
            cnt_next = cnt + 1'b1;
          end
        end
        CMD_REMOVE_FIRST: begin
          if (empty) begin
            r_status = ST_EMPTY;
          end else begin
            ctl.del_all = 1'b1;
            cnt_next    = cnt - 1'b1;
          end
        end
        CMD_REMOVE_LAST: begin
          if (!empty) begin
            cnt_next = cnt - 1'b1;
          end
        end
        CMD_REMOVE_VALUE, CMD_CONTAINS: begin
          start_scan = 1'b1;
        end
        CMD_HEAD: begin
          if (empty) begin
            r_status = ST_EMPTY;
          end else begin
            r_data = entries[0];
          end
        end
        CMD_TAIL: begin
          if (empty) begin
            r_status = ST_EMPTY;
          end else begin
            start_scan = 1'b1;
          end
        end
        CMD_CLEAR: begin
          cnt_next = '0;
        end
        default: begin
        end
      endcase
    end else if (fin_load && (cmd_q == CMD_REMOVE_VALUE) && carry) begin
      ctl.del_ge = 1'b1;
      cnt_next   = cnt - 1'b1;
    end
  end

  // sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      cnt <= cnt_next;
      case (state)
        S_IDLE: begin
          if (accept && start_scan) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (grp == LAST_GRP) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // search sweep registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      grp   <= '0;
      carry <= 1'b0;
      acc   <= '0;
      key   <= value;
      cmd_q <= command;
    end else if (state == S_SCAN) begin
      grp   <= grp + 1'b1;
      carry <= grp_seen[grp];
      acc   <= acc | grp_tail[grp];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !start_scan) || fin_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !start_scan) begin
      status   <= r_status;
      data_out <= r_data;
      found    <= 1'b0;
      count    <= cnt_next;
    end else if (fin_load) begin
      status   <= ST_OK;
      data_out <= (cmd_q == CMD_TAIL) ? acc : '0;
      found    <= carry && (cmd_q != CMD_TAIL);
      count    <= cnt_next;
    end
  end

  `OLB_ASSERT_IMPL(a_accept_idle, clk, rst, in_valid && !in_stall, state == S_IDLE)
  `OLB_ASSERT_NEXT(a_scan_end, clk, rst, state == S_SCAN && grp == LAST_GRP, state == S_FIN)
  `OLB_ASSERT_NEXT(a_full_add, clk, rst,
                   accept && command == CMD_ADD_LAST && cnt == CAP_C,
                   out_valid && status == ST_FULL && count == CAP_C)
  `OLB_ASSERT_NEXT(a_remove_hit, clk, rst,
                   fin_load && cmd_q == CMD_REMOVE_VALUE && carry,
                   cnt == $past(cnt) - 1'b1)

endmodule

>>> sv/olb_cell.sv
// One list slot: holds an entry, shifts with its neighbors, takes part in search.
// Depends on olb_pkg.
module olb_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 7,
  parameter int GW         = 3,
  parameter int INDEX      = 0
) (
  input  logic                  clk,
  input  olb_pkg::cell_ctl_t    ctl,
  input  logic [CW-1:0]         ins_pos,
  input  logic [CW-1:0]         cnt,
  input  logic [CW-1:0]         tail_pos,
  input  logic [GW-1:0]         grp,
  input  logic [DATA_WIDTH-1:0] ins_data,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] left_entry,
  input  logic [DATA_WIDTH-1:0] right_entry,
  input  logic                  seen_in,
  output logic [DATA_WIDTH-1:0] entry,
  output logic                  seen_out,
  output logic [DATA_WIDTH-1:0] tail_term
);
  import olb_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);
  localparam logic [GW-1:0] GRP = GW'(INDEX / GROUP_SIZE);

  logic in_grp;
  logic hit;
  logic ge;  // at or after the first match

  // search: compare against the key, pass the seen flag along the group
  assign in_grp    = ctl.scan && (grp == GRP);
  assign hit       = (IDX < cnt) && (entry == key);
  assign seen_out  = seen_in | hit;
  assign tail_term = (IDX == tail_pos) ? entry : '0;

  // entry update
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (IDX == ins_pos) begin
        entry <= ins_data;
      end else if (IDX > ins_pos) begin
        entry <= left_entry;
      end
    end else if (ctl.del_all || (ctl.del_ge && ge)) begin
      entry <= right_entry;
    end
  end

  // match prefix, held until the remove is applied
  always_ff @(posedge clk) begin
    if (in_grp) begin
      ge <= seen_out;
    end
  end

endmodule

>>> tb/sv/olb_list_checker.sv
// Scoreboard for the ordered list buffer: mirrors the list, predicts each result
// and compares it with what the block returns. Depends on olb_pkg only.
module olb_list_checker (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        in_valid,
  input  logic                                        in_stall,
  input  logic [3:0]                                  command,
  input  logic [olb_pkg::DATA_WIDTH_DEF-1:0]          value,
  input  logic [$clog2(olb_pkg::CAPACITY_DEF+1)-1:0]  position,
  input  logic                                        out_valid,
  input  logic                                        out_stall,
  input  logic [1:0]                                  status,
  input  logic [olb_pkg::DATA_WIDTH_DEF-1:0]          data_out,
  input  logic                                        found,
  input  logic [$clog2(olb_pkg::CAPACITY_DEF+1)-1:0]  count,
  output int                                          failures,
  output int                                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import olb_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int DW  = DATA_WIDTH_DEF;
  localparam int PW  = $clog2(CAPACITY_DEF+1);

  typedef struct packed {
    logic [1:0]    status;
    logic [DW-1:0] data;
    logic          found;
    logic [PW-1:0] count;
  } list_result_t;

  // mirror of the list contents
  logic [DW-1:0] list_mem [CAP];
  int            list_len;

  list_result_t  expected_q [$];
  int            fail_cnt = 0;

  // index of the first entry equal to val, -1 when absent
  function automatic int find_entry(input logic [DW-1:0] val);
    int i;
    for (i = 0; i < list_len; i++) begin
      if (list_mem[i] == val) return i;
    end
    return -1;
  endfunction

  // close the gap at index k
  function automatic void drop_entry(input int k);
    int i;
    for (i = k; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
    list_len--;
  endfunction

  // open a slot at index k and store val there
  function automatic void place_entry(input int k, input logic [DW-1:0] val);
    int i;
    for (i = list_len; i > k; i--) list_mem[i] = list_mem[i-1];
    list_mem[k] = val;
    list_len++;
  endfunction

  // apply one command to the mirror and return the result it should produce
  function automatic list_result_t apply_list_command(input logic [3:0]    cmd,
                                                      input logic [DW-1:0] val,
                                                      input logic [PW-1:0] pos);
    list_result_t r;
    int           hit;
    r = '0;
    case (cmd)
      CMD_ADD_FIRST: begin
        if (list_len >= CAP) r.status = ST_FULL;
        else place_entry(0, val);
      end
      CMD_ADD_LAST: begin
        if (list_len >= CAP) r.status = ST_FULL;
        else place_entry(list_len, val);
      end
      CMD_INSERT_AT: begin
        // range check comes ahead of the full check
        if (int'(pos) > list_len) r.status = ST_RANGE;
        else if (list_len >= CAP) r.status = ST_FULL;
        else place_entry(int'(pos), val);
      end
      CMD_REMOVE_FIRST: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else drop_entry(0);
      end
      CMD_REMOVE_LAST: begin
        // empty list: silent no-op
        if (list_len > 0) list_len--;
      end
      CMD_REMOVE_VALUE: begin
        hit = find_entry(val);
        if (hit >= 0) begin
          r.found = 1'b1;
          drop_entry(hit);
        end
      end
      CMD_CONTAINS: begin
        r.found = (find_entry(val) >= 0);
      end
      CMD_HEAD: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.data = list_mem[0];
      end
      CMD_TAIL: begin
        if (list_len == 0) r.status = ST_EMPTY;
        else r.data = list_mem[list_len-1];
      end
      CMD_CLEAR: begin
        list_len = 0;
      end
      default: begin
        // size and unused codes leave the list alone
      end
    endcase
    r.count = PW'(list_len);
    return r;
  endfunction

  // watch both channels; predict on input transactions, check on output ones
  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = 0;
      expected_q.delete();
    end else begin
      if (in_valid && !in_stall)
        expected_q.push_back(apply_list_command(command, value, position));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_cnt++;
        end else begin
          want = expected_q.pop_front();
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, status);
            fail_cnt++;
          end
          if (data_out !== want.data) begin
            $error("data_out mismatch: expected %h, actual %h", want.data, data_out);
            fail_cnt++;
          end
          if (found !== want.found) begin
            $error("found mismatch: expected %0d, actual %0d", want.found, found);
            fail_cnt++;
          end
          if (count !== want.count) begin
            $error("count mismatch: expected %0d, actual %0d", want.count, count);
            fail_cnt++;
          end
        end
      end
    end
    failures <= fail_cnt;
    pending  <= expected_q.size();
  end

endmodule

>>> tb/sv/ordered_list_buffer_unit_test.sv
// Top of the ordered list buffer testbench: clock, reset, command stimulus, result-side
// stalls, watchdog and verdict. Depends on olb_pkg, the buffer unit and olb_list_checker.
module ordered_list_buffer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import olb_pkg::*;

  localparam int DW             = DATA_WIDTH_DEF;
  localparam int PW             = $clog2(CAPACITY_DEF+1);
  localparam int BLOCKS         = 10;
  localparam int BLOCK_ITEMS    = 55;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum {MIX_GROW, MIX_SHRINK, MIX_ANY} cmd_mix_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  logic [3:0]    command   = CMD_SIZE;
  logic [DW-1:0] value     = '0;
  logic [PW-1:0] position  = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [1:0]    status;
  logic [DW-1:0] data_out;
  logic          found;
  logic [PW-1:0] count;

  int            failures;
  int            pending;
  int            tx_idle_pct  = 0;
  int            rx_stall_pct = 0;
  int            seen_count   = 0;
  int            quiet_cycles = 0;
  logic [DW-1:0] value_pool [8];

  ordered_list_buffer_unit u_top (
    .clk, .rst, .in_valid, .in_stall, .command, .value, .position,
    .out_valid, .out_stall, .status, .data_out, .found, .count
  );

  olb_list_checker u_check (
    .clk, .rst, .in_valid, .in_stall, .command, .value, .position,
    .out_valid, .out_stall, .status, .data_out, .found, .count,
    .failures(failures), .pending(pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result-side backpressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
  end

  // last count seen, used to aim insert positions
  always @(posedge clk) begin
    if (out_valid && !out_stall) seen_count <= count;
  end

  // watchdog: cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic set_idle_mode(input int k);
    case (k)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
      default: begin tx_idle_pct = 26; rx_stall_pct = 26; end
    endcase
  endtask

  // one command transaction; called and returns at a falling edge
  task automatic send_cmd(input logic [3:0] c, input logic [DW-1:0] v,
                          input logic [PW-1:0] p);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      command  <= 4'($urandom);
      value    <= $urandom;
      position <= PW'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    value    <= v;
    position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic cmd_mix_t block_mix(input int blk);
    case (blk)
      0, 1, 4, 6, 7: return MIX_GROW;
      3, 8:          return MIX_SHRINK;
      default:       return MIX_ANY;
    endcase
  endfunction

  function automatic logic [3:0] pick_command(input cmd_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 30)      return CMD_ADD_LAST;
        else if (r < 55) return CMD_ADD_FIRST;
        else if (r < 85) return CMD_INSERT_AT;
        else if (r < 89) return CMD_CONTAINS;
        else if (r < 92) return CMD_HEAD;
        else if (r < 95) return CMD_TAIL;
        else if (r < 97) return CMD_SIZE;
        else if (r < 99) return CMD_REMOVE_VALUE;
        else             return 4'($urandom_range(11, 15));
      end
      MIX_SHRINK: begin
        if (r < 25)      return CMD_REMOVE_FIRST;
        else if (r < 50) return CMD_REMOVE_LAST;
        else if (r < 75) return CMD_REMOVE_VALUE;
        else if (r < 80) return CMD_CONTAINS;
        else if (r < 85) return CMD_HEAD;
        else if (r < 90) return CMD_TAIL;
        else if (r < 93) return CMD_SIZE;
        else if (r < 96) return CMD_ADD_LAST;
        else if (r < 98) return CMD_CLEAR;
        else             return 4'($urandom_range(11, 15));
      end
      default: begin
        if (r < 95) return 4'($urandom_range(0, 10));
        else        return 4'($urandom_range(11, 15));
      end
    endcase
  endfunction

  // half from a small pool so searches hit and duplicates occur
  function automatic logic [DW-1:0] pick_value();
    if ($urandom_range(0, 1)) return value_pool[$urandom_range(0, 7)];
    else return $urandom;
  endfunction

  function automatic logic [PW-1:0] pick_position(input logic [3:0] c);
    int r;
    r = $urandom_range(0, 99);
    if (c == CMD_INSERT_AT && r < 80) return PW'($urandom_range(0, seen_count));
    else if (c == CMD_INSERT_AT && r < 90) return PW'($urandom_range(0, CAPACITY_DEF));
    else return PW'($urandom_range(0, (1 << PW) - 1));
  endfunction

  initial begin
    int       blk;
    int       n;
    logic [3:0] c;
    value_pool[0] = '0;
    value_pool[1] = '1;
    for (n = 2; n < 8; n++) value_pool[n] = $urandom;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: empty-list errors, range errors, extremes, unused codes
    set_idle_mode(0);
    send_cmd(CMD_REMOVE_FIRST, '0, '0);
    send_cmd(CMD_REMOVE_LAST, '0, '0);
    send_cmd(CMD_HEAD, '1, '0);
    send_cmd(CMD_TAIL, '1, '0);
    send_cmd(CMD_INSERT_AT, 32'h1111_2222, PW'(1));
    send_cmd(CMD_INSERT_AT, 32'h3333_4444, '1);
    send_cmd(CMD_INSERT_AT, '0, '0);
    send_cmd(CMD_ADD_LAST, '1, '0);
    send_cmd(CMD_ADD_FIRST, 32'hA5A5_5A5A, '0);
    send_cmd(CMD_INSERT_AT, 32'h1234_5678, PW'(3));
    send_cmd(CMD_CONTAINS, '1, '0);
    send_cmd(CMD_CONTAINS, 32'hDEAD_BEEF, '0);
    send_cmd(CMD_REMOVE_VALUE, 32'hDEAD_BEEF, '0);
    send_cmd(CMD_REMOVE_VALUE, '0, '0);
    send_cmd(CMD_HEAD, '0, '0);
    send_cmd(CMD_TAIL, '0, '0);
    send_cmd(CMD_SIZE, '0, '0);
    for (n = 11; n <= 15; n++) send_cmd(4'(n), $urandom, PW'($urandom));
    send_cmd(CMD_REMOVE_FIRST, '0, '0);
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_SIZE, '0, '0);

    // random blocks; grow blocks drive the list to full
    for (blk = 0; blk < BLOCKS; blk++) begin
      set_idle_mode(blk % 4);
      for (n = 0; n < BLOCK_ITEMS; n++) begin
        c = pick_command(block_mix(blk));
        send_cmd(c, pick_value(), pick_position(c));
      end
      if (blk == 4) begin
        // hold off until the block has drained
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
    end

    // drain and verdict
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
